@@ design/t3prd_pkg.sv @@
// Package for the T3 photon record decoder: beat types, record field layout,
// queue sizing and the internal operation codes. No dependencies.
`timescale 1ns / 1ps

package t3prd_pkg;

    // Width of the kept overflow offset; the reported sync time is 48 bits.
    localparam int SYNC_TIME_BITS = 48;
    localparam int OUT_TIME_BITS  = 48;

    // One overflow wrap spans this many sync periods (a power of two).
    localparam int WRAP_PERIOD = 1024;
    localparam int WRAP_SHIFT  = $clog2(WRAP_PERIOD);

    // Record field layout.
    localparam int NSYNC_BITS  = 10;
    localparam int DELAY_BITS  = 15;
    localparam int CHAN_BITS   = 6;
    localparam int MARKER_BITS = 4;

    localparam int NSYNC_LSB   = 0;
    localparam int DELAY_LSB   = 10;
    localparam int CHAN_LSB    = 25;
    localparam int SPECIAL_BIT = 31;

    localparam logic [CHAN_BITS-1:0] CHAN_OVERFLOW = 6'h3F;
    localparam logic [CHAN_BITS-1:0] MARKER_MIN    = 6'd1;
    localparam logic [CHAN_BITS-1:0] MARKER_MAX    = 6'd15;

    // Result kind codes.
    localparam logic KIND_PHOTON = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // Operation the back end carries out for one record.
    typedef enum logic [1:0] {
        OP_PHOTON,
        OP_MARKER,
        OP_OVERFLOW,
        OP_IGNORE
    } op_t;

    // Input beat.
    typedef struct packed {
        logic [31:0] record_word;
        logic        last_in_file;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic                     record_kind;
        logic [OUT_TIME_BITS-1:0] sync_time;
        logic [DELAY_BITS-1:0]    delay_time;
        logic [MARKER_BITS-1:0]   marker_channel;
        logic                     end_of_file;
    } out_beat_t;

    // Classified record held in the queue. For overflow records the sync
    // field already carries the wrap count.
    typedef struct packed {
        op_t                    op;
        logic [NSYNC_BITS-1:0]  nsync;
        logic [DELAY_BITS-1:0]  delay;
        logic [MARKER_BITS-1:0] marker;
        logic                   last;
    } entry_t;

endpackage

@@ design/t3prd_front.sv @@
// Front end of the T3 photon record decoder: accepts input beats, splits the
// record into fields and classifies it. Depends on t3prd_pkg.
`timescale 1ns / 1ps

module t3prd_front
    import t3prd_pkg::*;
(
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    input  logic     q_ready,
    output logic     q_push,
    output entry_t   q_entry
);

    logic                  special;
    logic [CHAN_BITS-1:0]  chan;
    logic [NSYNC_BITS-1:0] nsync;
    logic [DELAY_BITS-1:0] delay;

    // The front holds no state of its own; the queue absorbs stalls.
    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    // Field split.
    always_comb begin
        special = s_data.record_word[SPECIAL_BIT];
        chan    = s_data.record_word[CHAN_LSB +: CHAN_BITS];
        nsync   = s_data.record_word[NSYNC_LSB +: NSYNC_BITS];
        delay   = s_data.record_word[DELAY_LSB +: DELAY_BITS];
    end

    // Classification. An overflow with a zero sync field counts as one wrap.
    always_comb begin
        q_entry.nsync  = nsync;
        q_entry.delay  = delay;
        q_entry.marker = '0;
        q_entry.last   = s_data.last_in_file;
        if (!special) begin
            q_entry.op = OP_PHOTON;
        end else if (chan == CHAN_OVERFLOW) begin
            q_entry.op = OP_OVERFLOW;
            if (nsync == '0) begin
                q_entry.nsync = NSYNC_BITS'(1);
            end
        end else if (chan inside {[MARKER_MIN:MARKER_MAX]}) begin
            q_entry.op     = OP_MARKER;
            q_entry.marker = chan[MARKER_BITS-1:0];
        end else begin
            q_entry.op = OP_IGNORE;
        end
    end

endmodule

@@ design/t3prd_queue.sv @@
// Short first-word-fall-through queue of classified records between the
// front and back ends. Depends on t3prd_pkg.
`timescale 1ns / 1ps

module t3prd_queue
    import t3prd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   not_full,
    output logic   not_empty,
    input  logic   pop,
    output entry_t head
);

    entry_t                    store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      do_push, do_pop;

    assign not_full  = (count_reg != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        do_push     = push && not_full;
        do_pop      = pop && not_empty;
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(do_push);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(do_pop);
        count_next  = count_reg + (QUEUE_PTR_BITS+1)'(do_push)
                                - (QUEUE_PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/t3prd_back.sv @@
// Back end of the T3 photon record decoder: keeps the overflow offset, forms
// the corrected sync time and holds the result register. Depends on t3prd_pkg.
`timescale 1ns / 1ps

module t3prd_back
    import t3prd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_not_empty,
    input  entry_t    q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [SYNC_TIME_BITS-1:0] offset_reg, offset_next;
    logic [SYNC_TIME_BITS-1:0] sync_sum;
    logic [SYNC_TIME_BITS-1:0] wrap_add;
    logic                      out_valid_reg, out_valid_next;
    out_beat_t                 out_data_reg, out_data_next;
    logic                      gives_result;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A record leaves the queue whenever the result register is free or
    // being emptied in this cycle.
    assign q_pop = q_not_empty && (!out_valid_reg || m_ready);

    always_comb begin
        sync_sum     = offset_reg + SYNC_TIME_BITS'(q_head.nsync);
        wrap_add     = SYNC_TIME_BITS'({q_head.nsync, {WRAP_SHIFT{1'b0}}});
        gives_result = (q_head.op == OP_PHOTON) || (q_head.op == OP_MARKER);
    end

    // Offset update: overflow adds wraps, the last record clears it.
    always_comb begin
        offset_next = offset_reg;
        if (q_pop) begin
            if (q_head.last) begin
                offset_next = '0;
            end else if (q_head.op == OP_OVERFLOW) begin
                offset_next = offset_reg + wrap_add;
            end
        end
    end

    // Result register load.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop && gives_result) begin
            out_valid_next               = 1'b1;
            out_data_next.sync_time      = OUT_TIME_BITS'(sync_sum);
            out_data_next.end_of_file    = q_head.last;
            if (q_head.op == OP_MARKER) begin
                out_data_next.record_kind    = KIND_MARKER;
                out_data_next.delay_time     = '0;
                out_data_next.marker_channel = q_head.marker;
            end else begin
                out_data_next.record_kind    = KIND_PHOTON;
                out_data_next.delay_time     = q_head.delay;
                out_data_next.marker_channel = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ design/t3_photon_record_decoder.sv @@
// Channel  | Ports                        | Beat
// ---------+------------------------------+--------------------------------------
// input    | s_valid, s_ready, s_data     | in_beat_t: record word, last flag
// result   | m_valid, m_ready, m_data     | out_beat_t: kind, sync, delay, marker
//
// One record is accepted per cycle while the queue is not full; it is first
// written into the four-entry record queue, and its result then passes the
// offset adder into the result register to be offered. A record leaves the
// queue only while the result register is free or being emptied. Reset is
// synchronous and active low; it clears the overflow offset, empties the
// queue and drops the result valid. A stalled result holds in its register
// while the queue keeps taking records until it is full.
// Top level of the T3 photon record decoder. Depends on t3prd_pkg,
// t3prd_front, t3prd_queue and t3prd_back.
`timescale 1ns / 1ps

module t3_photon_record_decoder
    import t3prd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic   q_ready;
    logic   q_push;
    entry_t q_entry;
    logic   q_not_empty;
    logic   q_pop;
    entry_t q_head;

    // Accept and classify.
    t3prd_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Decoupling queue.
    t3prd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .not_full   (q_ready),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Offset correction and result register.
    t3prd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ design/t3prd_checker.sv @@
// Port-level checks for the T3 photon record decoder, bound to the top level.
// Depends on t3prd_pkg.
`timescale 1ns / 1ps

module t3prd_port_checks
    import t3prd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // A stalled result beat holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending and an empty queue ready for input.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the result and queue");

    // A marker beat carries a channel and no delay.
    a_marker_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_kind == KIND_MARKER |->
            m_data.delay_time == '0 && m_data.marker_channel != '0)
        else $error("marker beat with bad fields");

    // A photon beat carries no marker channel.
    a_photon_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_kind == KIND_PHOTON |->
            m_data.marker_channel == '0)
        else $error("photon beat with a marker channel");

    // The input side is never refused once the result has gone and nothing
    // arrived in the meantime.
    a_ready_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !s_valid ##1 !m_valid && !s_valid |-> s_ready)
        else $error("input refused while the decoder was drained");

endmodule

bind t3_photon_record_decoder t3prd_port_checks u_checker (.*);
